// File: rtl/core/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// shared types and constants for the box against plane classifier
// ----------------------------------------------------------------------------
package acp_pkg;

	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;
	localparam int COORD_W = 16;
	localparam int PROD_W  = 32;
	localparam int DIST_W  = 34;
	localparam int FRAC_W  = 14;
	localparam int SLOTS   = 6;

	// register indexes, one 64-bit register every 8 bytes
	localparam logic [2:0] REG_PLANE_COUNT = 3'd0;
	localparam logic [2:0] REG_PLANE_BASE  = 3'd1;

	localparam logic [2:0] PLANE_COUNT_RESET = 3'd6;

	// result codes
	localparam logic [1:0] SIDE_OUTSIDE   = 2'd0;
	localparam logic [1:0] SIDE_INTERSECT = 2'd1;
	localparam logic [1:0] SIDE_INSIDE    = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] offset;
		logic signed [COORD_W-1:0] nz;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] nx;
	} plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] max_z;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_x;
	} box_t;

	typedef struct packed {
		logic front;
		logic behind;
	} plane_flags_t;

endpackage

// File: rtl/core/acp_regs.sv
// ----------------------------------------------------------------------------
// acp_regs
// apb register file: active plane count and the packed plane words
// ----------------------------------------------------------------------------
module acp_regs #(
	parameter int NUM_PLANES = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [acp_pkg::ADDR_W-1:0]          paddr,
	input  logic [acp_pkg::DATA_W-1:0]          pwdata,
	output logic [acp_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	output logic [2:0]                          plane_count,
	output acp_pkg::plane_t [NUM_PLANES-1:0]    planes
);
	import acp_pkg::*;

	logic       wr_en;
	logic [2:0] idx;
	logic [2:0] count_q;
	plane_t [NUM_PLANES-1:0] planes_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= PLANE_COUNT_RESET;
			planes_q <= '0;
		end else if (wr_en) begin
			if (idx == REG_PLANE_COUNT) begin
				count_q <= pwdata[2:0];
			end
			for (int k = 0; k < NUM_PLANES; k++) begin
				if (idx == REG_PLANE_BASE + 3'(k)) begin
					planes_q[k] <= pwdata;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (idx == REG_PLANE_COUNT) begin
			prdata = DATA_W'(count_q);
		end
		for (int k = 0; k < NUM_PLANES; k++) begin
			if (idx == REG_PLANE_BASE + 3'(k)) begin
				prdata = planes_q[k];
			end
		end
	end

	assign plane_count = count_q;
	assign planes      = planes_q;

endmodule

// File: rtl/core/acp_plane.sv
// ----------------------------------------------------------------------------
// acp_plane
// one plane lane: corner select and multiply, distance sums, threshold compare
// ----------------------------------------------------------------------------
module acp_plane (
	input  logic                  clk,
	input  logic                  en,
	input  acp_pkg::plane_t       plane,
	input  acp_pkg::box_t         box,
	output acp_pkg::plane_flags_t flags_s3
);
	import acp_pkg::*;

	logic signed [COORD_W-1:0] n      [3];
	logic signed [COORD_W-1:0] lo     [3];
	logic signed [COORD_W-1:0] hi     [3];
	logic signed [PROD_W-1:0]  pmin_s1 [3];
	logic signed [PROD_W-1:0]  pmax_s1 [3];
	logic signed [DIST_W-1:0]  dmin_s2;
	logic signed [DIST_W-1:0]  dmax_s2;
	logic signed [DIST_W-1:0]  thr_s2;

	always_comb begin
		n[0]  = plane.nx;
		n[1]  = plane.ny;
		n[2]  = plane.nz;
		lo[0] = box.min_x;
		lo[1] = box.min_y;
		lo[2] = box.min_z;
		hi[0] = box.max_x;
		hi[1] = box.max_y;
		hi[2] = box.max_z;
	end

	// a zero normal gives zero either way, so the sign bit alone picks the corner
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				if (!n[a][COORD_W-1]) begin
					pmin_s1[a] <= PROD_W'(n[a]) * PROD_W'(lo[a]);
					pmax_s1[a] <= PROD_W'(n[a]) * PROD_W'(hi[a]);
				end else begin
					pmin_s1[a] <= PROD_W'(n[a]) * PROD_W'(hi[a]);
					pmax_s1[a] <= PROD_W'(n[a]) * PROD_W'(lo[a]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmin_s2 <= DIST_W'(pmin_s1[0]) + DIST_W'(pmin_s1[1]) + DIST_W'(pmin_s1[2]);
			dmax_s2 <= DIST_W'(pmax_s1[0]) + DIST_W'(pmax_s1[1]) + DIST_W'(pmax_s1[2]);
			// offset moved to q.14 and negated
			thr_s2  <= -$signed({{(DIST_W-COORD_W-FRAC_W){plane.offset[COORD_W-1]}},
				plane.offset, {FRAC_W{1'b0}}});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3.front  <= dmin_s2 >= thr_s2;
			flags_s3.behind <= dmax_s2 <= thr_s2;
		end
	end

endmodule

// File: rtl/core/aabb_plane_classify.sv
// ----------------------------------------------------------------------------
// aabb_plane_classify
// classifies an axis-aligned box against up to NUM_PLANES configured planes
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  box       box_valid/box_ready    min_x min_y min_z max_x max_y max_z
//  result    res_valid/res_ready    side
//  config    apb psel/penable       paddr pwdata prdata (8 bytes per register)
//
//  one box per cycle while the result side does not stall; four register
//  stages (multiply, three-term sum, compare, combine) lie between box and result
//  no clearing pass: reset loads the registers at once
//  a stall on the result side holds the whole pipeline; box_ready is high when
//  the output word is free or res_ready is high, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module aabb_plane_classify #(
	parameter int NUM_PLANES = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [acp_pkg::ADDR_W-1:0]  paddr,
	input  logic [acp_pkg::DATA_W-1:0]  pwdata,
	output logic [acp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        box_valid,
	output logic                        box_ready,
	input  logic signed [15:0]          min_x,
	input  logic signed [15:0]          min_y,
	input  logic signed [15:0]          min_z,
	input  logic signed [15:0]          max_x,
	input  logic signed [15:0]          max_y,
	input  logic signed [15:0]          max_z,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [1:0]                  side
);
	import acp_pkg::*;

	localparam logic [2:0] NP = 3'(NUM_PLANES);

	logic                         en;
	logic [2:0]                   plane_count;
	logic [2:0]                   count_sat;
	plane_t [NUM_PLANES-1:0]      planes;
	plane_flags_t [NUM_PLANES-1:0] flags_s3;
	box_t                         box;
	logic                         v_s1, v_s2, v_s3, v_s4;
	logic [1:0]                   side_s4;
	logic                         behind_any;
	logic                         all_front;
	logic [1:0]                   side_d;

	acp_regs #(
		.NUM_PLANES (NUM_PLANES)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.plane_count (plane_count),
		.planes      (planes)
	);

	assign box.min_x = min_x;
	assign box.min_y = min_y;
	assign box.min_z = min_z;
	assign box.max_x = max_x;
	assign box.max_y = max_y;
	assign box.max_z = max_z;

	// whole pipeline moves whenever the output word is free or being taken
	assign en        = !v_s4 || res_ready;
	assign box_ready = en;

	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
		acp_plane u_plane (
			.clk      (clk),
			.en       (en),
			.plane    (planes[g]),
			.box      (box),
			.flags_s3 (flags_s3[g])
		);
	end

	assign count_sat = (plane_count > NP) ? NP : plane_count;

	always_comb begin
		behind_any = 1'b0;
		all_front  = 1'b1;
		for (int k = 0; k < NUM_PLANES; k++) begin
			if (3'(k) < count_sat) begin
				if (!flags_s3[k].front) begin
					all_front = 1'b0;
					if (flags_s3[k].behind) begin
						behind_any = 1'b1;
					end
				end
			end
		end
		if (behind_any) begin
			side_d = SIDE_OUTSIDE;
		end else if (count_sat != 3'd0 && all_front) begin
			side_d = SIDE_INSIDE;
		end else begin
			side_d = SIDE_INTERSECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= box_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_d;
		end
	end

	assign res_valid = v_s4;
	assign side      = side_s4;

endmodule
